@@ hdl/asfm_pkg.sv @@
// Shared types, constants and helpers for the scale frame decoder.
`default_nettype none
package asfm_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int STORE_DEPTH = 9;
  localparam int POS_W       = 4;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // Six digits per frame in both formats.
  localparam int DIGITS = 6;
  // 127 times the imperial digit value stays below 2**32; one sign bit and one spare.
  localparam int ACC_W     = 34;
  localparam int STEP_W    = 3;
  localparam int HEIGHT_W  = 32;

  // Division by 50: halve, then multiply by ceil(2**36 / 25) and keep the bits from 36 up.
  // This is exact for every halved magnitude below 2**31.
  localparam int                 HALF_W   = 31;
  localparam int                 RECIP_W  = 32;
  localparam logic [RECIP_W-1:0] RECIP_25 = 32'd2748779070;
  localparam int                 RECIP_SH = 36;
  localparam int                 PROD_W   = HALF_W + RECIP_W;
  localparam int                 QUOT_W   = PROD_W - RECIP_SH;

  typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

  typedef enum logic [1:0] {
    KIND_METRIC   = 2'd0,
    KIND_IMPERIAL = 2'd1,
    KIND_OTHER    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_HORNER,
    CV_SCALE,
    CV_MUL,
    CV_ABS,
    CV_DIV,
    CV_FIN
  } cv_state_t;

  typedef struct packed {
    logic start;
    logic imperial;
    logic negative;
  } cmd_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [HEIGHT_W-1:0] height;
  } rsp_t;

  // Frame position of the idx-th digit, most significant first.
  function automatic logic [STORE_IDX_W-1:0] digit_pos(input logic imperial,
                                                       input logic [2:0] idx);
    logic [STORE_IDX_W-1:0] p;
    p = STORE_IDX_W'(1);
    case (idx)
      3'd0:    p = STORE_IDX_W'(1);
      3'd1:    p = STORE_IDX_W'(2);
      3'd2:    p = imperial ? STORE_IDX_W'(4) : STORE_IDX_W'(3);
      3'd3:    p = imperial ? STORE_IDX_W'(5) : STORE_IDX_W'(4);
      3'd4:    p = STORE_IDX_W'(6);
      default: p = STORE_IDX_W'(7);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ hdl/asfm_conv.sv @@
// Iterative converter: digit accumulation, then metric scaling by ten or inch scaling and division by 50.
`default_nettype none
module asfm_conv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire asfm_pkg::cmd_t    cmd,
  input  wire asfm_pkg::frame_t  frame,
  output asfm_pkg::rsp_t         rsp
);

  asfm_pkg::cv_state_t state_r, state_nxt;
  logic signed [asfm_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [asfm_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic                                 imp_r, imp_nxt;
  logic                                 sgn_r, sgn_nxt;

  logic [7:0]                           cur_byte;
  logic signed [8:0]                    dig;
  logic signed [asfm_pkg::ACC_W-1:0]    dig_ext;
  logic signed [asfm_pkg::ACC_W-1:0]    mul10;
  logic [asfm_pkg::PROD_W-1:0]          prod;
  logic [asfm_pkg::HEIGHT_W-1:0]        mag32;

  assign cur_byte = frame[asfm_pkg::digit_pos(imp_r, step_r)];
  // The digit is the byte minus the code of zero; anything from -48 to 207.
  assign dig      = $signed({1'b0, cur_byte} - {1'b0, asfm_pkg::CHAR_ZERO});
  assign dig_ext  = {{(asfm_pkg::ACC_W-9){dig[8]}}, dig};
  assign mul10    = (acc_r <<< 3) + (acc_r <<< 1);

  assign prod     = {{(asfm_pkg::PROD_W-asfm_pkg::HALF_W){1'b0}}, acc_r[asfm_pkg::HALF_W:1]}
                  * {{(asfm_pkg::PROD_W-asfm_pkg::RECIP_W){1'b0}}, asfm_pkg::RECIP_25};
  assign mag32    = acc_r[asfm_pkg::HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asfm_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    imp_r  <= imp_nxt;
    sgn_r  <= sgn_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    step_nxt   = step_r;
    imp_nxt    = imp_r;
    sgn_nxt    = sgn_r;
    rsp.busy   = (state_r != asfm_pkg::CV_IDLE);
    rsp.done   = 1'b0;
    rsp.height = sgn_r ? (~mag32 + asfm_pkg::HEIGHT_W'(1)) : mag32;

    unique case (state_r)
      asfm_pkg::CV_IDLE: begin
        if (cmd.start) begin
          state_nxt = asfm_pkg::CV_HORNER;
          acc_nxt   = '0;
          step_nxt  = '0;
          imp_nxt   = cmd.imperial;
          sgn_nxt   = cmd.negative;
        end
      end
      asfm_pkg::CV_HORNER: begin
        acc_nxt  = mul10 + dig_ext;
        step_nxt = step_r + asfm_pkg::STEP_W'(1);
        if (step_r == asfm_pkg::STEP_W'(asfm_pkg::DIGITS - 1)) begin
          state_nxt = imp_r ? asfm_pkg::CV_MUL : asfm_pkg::CV_SCALE;
          step_nxt  = '0;
        end
      end
      asfm_pkg::CV_SCALE: begin
        // Metric digits end at tens of micrometers.
        acc_nxt   = mul10;
        state_nxt = asfm_pkg::CV_FIN;
      end
      asfm_pkg::CV_MUL: begin
        // Imperial digits end at hundreds of micro-inches, so the height is
        // 127 times the digit value over 50. Times 127 as times 128 minus one.
        acc_nxt   = (acc_r <<< 7) - acc_r;
        state_nxt = asfm_pkg::CV_ABS;
      end
      asfm_pkg::CV_ABS: begin
        acc_nxt   = acc_r[asfm_pkg::ACC_W-1] ? -acc_r : acc_r;
        sgn_nxt   = sgn_r ^ acc_r[asfm_pkg::ACC_W-1];
        state_nxt = asfm_pkg::CV_DIV;
      end
      asfm_pkg::CV_DIV: begin
        // Dividing the magnitude truncates toward zero once the sign is put back.
        acc_nxt   = {{(asfm_pkg::ACC_W-asfm_pkg::QUOT_W){1'b0}},
                     prod[asfm_pkg::PROD_W-1:asfm_pkg::RECIP_SH]};
        state_nxt = asfm_pkg::CV_FIN;
      end
      asfm_pkg::CV_FIN: begin
        rsp.done  = 1'b1;
        state_nxt = asfm_pkg::CV_IDLE;
      end
      default: begin
        state_nxt = asfm_pkg::CV_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/ascii_scale_frame_to_micrometers.sv @@
// A height beat follows every frame; an unrecognized frame keeps the last height.
// Bytes are taken one per cycle; after a recognized frame's last byte input stalls
// until the shared converter finishes (digit steps, scaling and, for imperial
// frames, a reciprocal multiply by 1/50).
// Synchronous active-low reset clears the byte position, last height and out valid.
`default_nettype none
module ascii_scale_frame_to_micrometers (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_height_um,
  output logic [31:0]      out_advance_um,
  output logic [1:0]       out_frame_kind
);

  logic [asfm_pkg::POS_W-1:0]    pos_r;
  asfm_pkg::frame_t              frame_r;
  logic [asfm_pkg::HEIGHT_W-1:0] last_height_r;
  logic                          out_valid_r;
  logic [asfm_pkg::HEIGHT_W-1:0] out_height_r;
  logic [asfm_pkg::HEIGHT_W-1:0] out_advance_r;
  asfm_pkg::kind_t               out_kind_r;
  // Frame kind of the conversion in flight, captured when it starts.
  logic                          u_conv_imp_hold;

  logic             last_pos;
  logic             in_fire;
  logic             frame_end;
  logic             is_metric;
  logic             is_imperial;
  asfm_pkg::cmd_t   cmd;
  asfm_pkg::rsp_t   rsp;

  assign last_pos    = (pos_r == asfm_pkg::POS_W'(asfm_pkg::FRAME_BYTES - 1));
  // The last byte waits while a finished beat is still held at the output.
  assign in_stall    = rsp.busy || (out_valid_r && last_pos);
  assign in_fire     = in_valid && !in_stall;
  assign frame_end   = in_fire && last_pos;
  assign is_metric   = (frame_r[5] == asfm_pkg::CHAR_DOT);
  assign is_imperial = !is_metric && (frame_r[3] == asfm_pkg::CHAR_DOT);

  assign cmd.start    = frame_end && (is_metric || is_imperial);
  assign cmd.imperial = is_imperial;
  assign cmd.negative = (frame_r[0] == asfm_pkg::CHAR_MINUS);

  asfm_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .frame (frame_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      last_height_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r <= last_pos ? '0 : pos_r + asfm_pkg::POS_W'(1);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (rsp.done) begin
        out_valid_r   <= 1'b1;
        last_height_r <= rsp.height;
      end else if (frame_end && !is_metric && !is_imperial) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (pos_r < asfm_pkg::POS_W'(asfm_pkg::STORE_DEPTH))) begin
      frame_r[pos_r[asfm_pkg::STORE_IDX_W-1:0]] <= in_rx_byte;
    end
    if (rsp.done) begin
      out_height_r  <= rsp.height;
      out_advance_r <= last_height_r - rsp.height;
      out_kind_r    <= (rsp.busy && u_conv_imp_hold) ? asfm_pkg::KIND_IMPERIAL
                                                     : asfm_pkg::KIND_METRIC;
    end else if (frame_end && !is_metric && !is_imperial) begin
      out_height_r  <= last_height_r;
      out_advance_r <= '0;
      out_kind_r    <= asfm_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      u_conv_imp_hold <= is_imperial;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_height_um  = out_height_r;
  assign out_advance_um = out_advance_r;
  assign out_frame_kind = out_kind_r;

endmodule
`default_nettype wire

@@ dv/ascii_scale_frame_to_micrometers_tb.sv @@
// Self-checking testbench for the scale frame decoder: byte stream in, height beats out.
module ascii_scale_frame_to_micrometers_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 100;

  typedef struct {
    logic [31:0]     height;
    logic [31:0]     advance;
    asfm_pkg::kind_t kind;
  } height_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_height_um;
  logic [31:0] out_advance_um;
  logic [1:0]  out_frame_kind;

  ascii_scale_frame_to_micrometers uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_height_um  (out_height_um),
    .out_advance_um (out_advance_um),
    .out_frame_kind (out_frame_kind)
  );

  logic [7:0]   rx_byte_q[$];
  height_beat_t height_q[$];
  int           pushed_cnt = 0;
  int           taken_cnt = 0;
  int           err_count = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           hold_req_count = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  logic         in_took = 1'b0;

  // Decoder state mirrored on the testbench side.
  int           frame_pos = 0;
  logic [7:0]   frame_bytes [asfm_pkg::STORE_DEPTH];
  logic [31:0]  prev_height = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint digit_val(input logic [7:0] b);
    longint d;
    d = b;
    return d - 48;
  endfunction

  task automatic decode_scale_byte(input logic [7:0] b);
    longint       v;
    height_beat_t beat;
    if (frame_pos < asfm_pkg::STORE_DEPTH) frame_bytes[frame_pos] = b;
    if (frame_pos + 1 < asfm_pkg::FRAME_BYTES) begin
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (frame_bytes[5] == asfm_pkg::CHAR_DOT) begin
        v = digit_val(frame_bytes[1]) * 1000000 + digit_val(frame_bytes[2]) * 100000
          + digit_val(frame_bytes[3]) * 10000 + digit_val(frame_bytes[4]) * 1000
          + digit_val(frame_bytes[6]) * 100 + digit_val(frame_bytes[7]) * 10;
        if (frame_bytes[0] == asfm_pkg::CHAR_MINUS) v = -v;
        beat.height = v[31:0];
        beat.kind = asfm_pkg::KIND_METRIC;
      end else if (frame_bytes[3] == asfm_pkg::CHAR_DOT) begin
        v = digit_val(frame_bytes[1]) * 10000000 + digit_val(frame_bytes[2]) * 1000000
          + digit_val(frame_bytes[4]) * 100000 + digit_val(frame_bytes[5]) * 10000
          + digit_val(frame_bytes[6]) * 1000 + digit_val(frame_bytes[7]) * 100;
        v = v * ((frame_bytes[0] == asfm_pkg::CHAR_MINUS) ? -64'sd254 : 64'sd254);
        // Signed 64-bit division truncates toward zero.
        v = v / 64'sd10000;
        beat.height = v[31:0];
        beat.kind = asfm_pkg::KIND_IMPERIAL;
      end else begin
        beat.height = prev_height;
        beat.kind = asfm_pkg::KIND_OTHER;
      end
      beat.advance = prev_height - beat.height;
      prev_height = beat.height;
      height_q.push_back(beat);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic push_frame(input asfm_pkg::frame_t f);
    for (int p = 0; p < asfm_pkg::FRAME_BYTES; p++) begin
      if (p < asfm_pkg::STORE_DEPTH) rx_byte_q.push_back(f[p]);
      else rx_byte_q.push_back(8'($urandom_range(0, 255)));
    end
    pushed_cnt += asfm_pkg::FRAME_BYTES;
  endtask

  task automatic push_random_frame();
    asfm_pkg::frame_t f;
    int               sel;
    int               dot_at;
    for (int p = 0; p < asfm_pkg::STORE_DEPTH; p++)
      f[p] = 8'(asfm_pkg::CHAR_ZERO + $urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0, 1:    f[0] = asfm_pkg::CHAR_MINUS;
      2:       f[0] = 8'h2B;
      default: f[0] = 8'($urandom_range(0, 255));
    endcase
    f[8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h0D;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      f[5] = asfm_pkg::CHAR_DOT;
      // A dot at both places must still decode as metric.
      if ($urandom_range(0, 9) == 0) f[3] = asfm_pkg::CHAR_DOT;
    end else if (sel < 70) begin
      f[3] = asfm_pkg::CHAR_DOT;
    end else if (sel < 80) begin
      for (int p = 0; p < asfm_pkg::STORE_DEPTH; p++) f[p] = 8'($urandom_range(0, 255));
    end else if (sel < 90) begin
      // Well-placed dot, but the digit bytes are arbitrary.
      dot_at = ($urandom_range(0, 1) == 0) ? 5 : 3;
      for (int p = 1; p < 8; p++) f[p] = 8'($urandom_range(0, 255));
      f[dot_at] = asfm_pkg::CHAR_DOT;
    end
    push_frame(f);
  endtask

  task automatic wait_all_done();
    while (taken_cnt != pushed_cnt || height_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_frames(input int n);
    for (int i = 0; i < n; i++) push_random_frame();
    wait_all_done();
  endtask

  // Sender: a new byte goes out only once the current one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (rx_byte_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_byte_q.pop_front();
      end else begin
        in_valid   <= 1'b0;
        in_rx_byte <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req_count != hold_seen) begin
      hold_seen = hold_req_count;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Check the oldest expectation before predicting from this edge's byte.
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (height_q.size() == 0) begin
        report_mismatch("height beat with none expected", out_height_um, 32'h0);
      end else begin
        if (out_height_um !== height_q[0].height)
          report_mismatch("height_um", out_height_um, height_q[0].height);
        if (out_advance_um !== height_q[0].advance)
          report_mismatch("advance_um", out_advance_um, height_q[0].advance);
        if (out_frame_kind !== height_q[0].kind)
          report_mismatch("frame_kind", 32'(out_frame_kind), 32'(height_q[0].kind));
        void'(height_q.pop_front());
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      taken_cnt++;
      decode_scale_byte(in_rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct  = 9;
    rx_stall_pct = 81;

    // Negative metric frame with a dot at both places and 0xFF in the other digit bytes.
    push_frame({8'hFF, 8'hFF, 8'hFF, asfm_pkg::CHAR_DOT, 8'hFF, asfm_pkg::CHAR_DOT,
                8'hFF, 8'hFF, asfm_pkg::CHAR_MINUS});
    // Imperial frame with 0x00 digit bytes: negative product, truncated toward zero.
    push_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, asfm_pkg::CHAR_DOT, 8'h00, 8'h00,
                8'h2B});
    // No dot anywhere: the height is kept.
    push_frame({asfm_pkg::STORE_DEPTH{8'h00}});
    wait_all_done();

    run_random_frames(50);

    tx_idle_pct  = 81;
    rx_stall_pct = 9;
    run_random_frames(45);

    // Long receiver hold-off while the sender keeps offering bytes.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req_count++;
    run_random_frames(20);

    run_random_frames(40);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (height_q.size() != 0)
      report_mismatch("height beats still expected", 32'h0, 32'(height_q.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/asfm_pkg.sv
hdl/asfm_conv.sv
hdl/ascii_scale_frame_to_micrometers.sv
dv/ascii_scale_frame_to_micrometers_tb.sv
